FILE: rtl/msgfp_pkg.sv
// Shared types, codes and character constants for the message frame parser.
`timescale 1ns / 1ps

package msgfp_pkg;

    localparam int unsigned LENGTH_BITS_DEF = 24;
    localparam int unsigned MAX_PAYLOAD_W   = 24;
    localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 24'd1048576;

    localparam int unsigned ACC_W = 32;
    localparam logic [ACC_W-1:0] ACC_CAP   = 32'h8000_0001;
    localparam logic [ACC_W-1:0] INT_MAX_V = 32'h7FFF_FFFF;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_G     = 8'h47;

    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_PAYLOAD  = 2'd1,
        PH_AWAIT_CR = 2'd2,
        PH_AWAIT_LF = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DELIM    = 3'd0,
        KIND_TOKEN    = 3'd1,
        KIND_PAYLOAD  = 3'd2,
        KIND_HDR_OK   = 3'd3,
        KIND_FRAME_OK = 3'd4,
        KIND_ERROR    = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_MALFORMED  = 3'd1,
        ERR_SYNTAX     = 3'd2,
        ERR_TOO_MANY   = 3'd3,
        ERR_BAD_COUNT  = 3'd4,
        ERR_NO_CR      = 3'd5,
        ERR_NO_LF      = 3'd6,
        ERR_OVER_LIMIT = 3'd7
    } err_t;

    // Command match progress: characters of MSG matched, or mismatch.
    localparam logic [2:0] CMD_FULL     = 3'd3;
    localparam logic [2:0] CMD_MISMATCH = 3'd4;

    localparam logic [2:0] TOKEN_CAP = 3'd6;
    localparam logic [2:0] TOKEN_MAX_TAG = 3'd4;

    typedef struct packed {
        logic stop;
        logic digit;
        logic neg;
        logic started;
    } count_flags_t;

endpackage

FILE: rtl/msgfp_count.sv
// Count token scanner: one byte step of the signed decimal reader.
`timescale 1ns / 1ps

module msgfp_count
    import msgfp_pkg::*;
(
    input  logic [7:0]       data_byte,
    input  logic             restart,
    input  logic [ACC_W-1:0] acc,
    input  count_flags_t     flags,
    output logic [ACC_W-1:0] acc_next,
    output count_flags_t     flags_next
);

    logic [ACC_W-1:0] acc_in;
    count_flags_t     fl_in;
    logic             is_digit;
    logic [ACC_W+3:0] prod;

    always_comb
    begin
        acc_in   = restart ? '0 : acc;
        fl_in    = restart ? '0 : flags;
        is_digit = (data_byte inside {[CH_ZERO:CH_NINE]});
        // times ten as two shifted copies, plus the digit value
        prod = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0}
             + {{(ACC_W){1'b0}}, data_byte[3:0]};

        acc_next   = acc_in;
        flags_next = fl_in;
        if (!fl_in.stop)
        begin
            flags_next.started = 1'b1;
            if (!fl_in.started && data_byte == CH_PLUS)
            begin
                flags_next.started = 1'b1;
            end
            else if (!fl_in.started && data_byte == CH_MINUS)
            begin
                flags_next.neg = 1'b1;
            end
            else if (is_digit)
            begin
                acc_next = (prod > {4'b0000, ACC_CAP}) ? ACC_CAP : prod[ACC_W-1:0];
                flags_next.digit = 1'b1;
            end
            else
            begin
                flags_next.stop = 1'b1;
            end
        end
    end

endmodule

FILE: rtl/msg_frame_stream_parser_core.sv
// Top level of the message frame parser: header tokeniser, payload counter, trailer check.
`timescale 1ns / 1ps

// Channel   | Handshake                  | Beat content
// ----------+----------------------------+---------------------------------------------
// input     | byte_valid / byte_ready    | data_byte
// result    | result_valid / result_ready| out_byte, kind, token_number, has_reply_to,
//           |                            | payload_length, error_code
// config    | cfg_valid / cfg_ready      | max_payload_bytes
//
// Every input beat yields exactly one result beat, registered in the cycle after the byte is taken.
// A new byte is taken every cycle while the result register is empty or being drained;
// the single result register is the only thing that throttles the input side.
// Reset (rst_n low, asynchronous) returns to the header phase with an empty line and
// a limit of 1048576 bytes. The config channel is always ready.

module msg_frame_stream_parser_core
    import msgfp_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     byte_valid,
    output logic                     byte_ready,
    input  logic [7:0]               data_byte,

    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [7:0]               out_byte,
    output logic [2:0]               kind,
    output logic [2:0]               token_number,
    output logic                     has_reply_to,
    output logic [LENGTH_BITS-1:0]   payload_length,
    output logic [2:0]               error_code,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [MAX_PAYLOAD_W-1:0] max_payload_bytes
);

    // Parser state
    phase_t                 phase_reg, phase_next;
    logic                   prev_cr_reg, prev_cr_next;
    logic                   nonempty_reg, nonempty_next;
    logic                   in_tok_reg, in_tok_next;
    logic [2:0]             tok_cnt_reg, tok_cnt_next;
    logic [2:0]             cmd_reg, cmd_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    count_flags_t           flags_reg, flags_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [LENGTH_BITS-1:0] held_len_reg, held_len_next;
    logic                   held_reply_reg, held_reply_next;
    logic [MAX_PAYLOAD_W-1:0] limit_reg;

    // Result register
    logic                   rvalid_reg;
    logic [7:0]             rbyte_reg;
    kind_t                  rkind_reg, rkind_next;
    logic [2:0]             rtok_reg, rtok_next;
    logic                   rreply_reg, rreply_next;
    logic [LENGTH_BITS-1:0] rlen_reg, rlen_next;
    err_t                   rerr_reg, rerr_next;

    logic                   take;
    logic                   is_space;
    logic                   tok_start;
    logic [2:0]             tok_cnt_eff;
    logic [ACC_W-1:0]       scan_acc;
    count_flags_t           scan_flags;
    err_t                   hdr_err;
    logic [7:0]             cmd_char;

    assign byte_ready   = !rvalid_reg || result_ready;
    assign take         = byte_valid && byte_ready;
    assign cfg_ready    = 1'b1;

    assign result_valid   = rvalid_reg;
    assign out_byte       = rbyte_reg;
    assign kind           = rkind_reg;
    assign token_number   = rtok_reg;
    assign has_reply_to   = rreply_reg;
    assign payload_length = rlen_reg;
    assign error_code     = rerr_reg;

    assign is_space  = (data_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR});
    assign tok_start = !is_space && !in_tok_reg;
    assign tok_cnt_eff = (tok_start && tok_cnt_reg < TOKEN_CAP) ? tok_cnt_reg + 3'd1
                                                                : tok_cnt_reg;

    msgfp_count u_count (
        .data_byte  (data_byte),
        .restart    (tok_start),
        .acc        (acc_reg),
        .flags      (flags_reg),
        .acc_next   (scan_acc),
        .flags_next (scan_flags)
    );

    // Line checks at the closing LF, in priority order
    always_comb
    begin
        if (!prev_cr_reg || !nonempty_reg)
            hdr_err = ERR_MALFORMED;
        else if (tok_cnt_reg < 3'd4 || cmd_reg != CMD_FULL)
            hdr_err = ERR_SYNTAX;
        else if (tok_cnt_reg > 3'd5)
            hdr_err = ERR_TOO_MANY;
        else if (!flags_reg.digit)
            hdr_err = ERR_BAD_COUNT;
        else if (flags_reg.neg && acc_reg != '0)
            hdr_err = ERR_BAD_COUNT;
        else if (!flags_reg.neg && acc_reg > INT_MAX_V)
            hdr_err = ERR_BAD_COUNT;
        else if (acc_reg > {{(ACC_W-MAX_PAYLOAD_W){1'b0}}, limit_reg}
                 || acc_reg[ACC_W-1:LENGTH_BITS] != '0)
            hdr_err = ERR_OVER_LIMIT;
        else
            hdr_err = ERR_NONE;
    end

    always_comb
    begin
        case (cmd_reg)
            3'd0:    cmd_char = CH_M;
            3'd1:    cmd_char = CH_S;
            default: cmd_char = CH_G;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        prev_cr_next    = prev_cr_reg;
        nonempty_next   = nonempty_reg;
        in_tok_next     = in_tok_reg;
        tok_cnt_next    = tok_cnt_reg;
        cmd_next        = cmd_reg;
        acc_next        = acc_reg;
        flags_next      = flags_reg;
        left_next       = left_reg;
        held_len_next   = held_len_reg;
        held_reply_next = held_reply_reg;

        rkind_next  = KIND_DELIM;
        rtok_next   = '0;
        rreply_next = 1'b0;
        rlen_next   = '0;
        rerr_next   = ERR_NONE;

        case (phase_reg)
            PH_HEADER:
            begin
                if (data_byte == CH_LF)
                begin
                    if (hdr_err != ERR_NONE)
                    begin
                        rkind_next = KIND_ERROR;
                        rerr_next  = hdr_err;
                    end
                    else
                    begin
                        rkind_next      = KIND_HDR_OK;
                        held_len_next   = acc_reg[LENGTH_BITS-1:0];
                        held_reply_next = (tok_cnt_reg == 3'd5);
                        left_next       = acc_reg[LENGTH_BITS-1:0];
                        rreply_next     = (tok_cnt_reg == 3'd5);
                        rlen_next       = acc_reg[LENGTH_BITS-1:0];
                        phase_next      = (acc_reg[LENGTH_BITS-1:0] == '0) ? PH_AWAIT_CR
                                                                           : PH_PAYLOAD;
                    end
                    // drop the line either way
                    prev_cr_next  = 1'b0;
                    nonempty_next = 1'b0;
                    in_tok_next   = 1'b0;
                    tok_cnt_next  = '0;
                    cmd_next      = '0;
                    acc_next      = '0;
                    flags_next    = '0;
                end
                else
                begin
                    nonempty_next = 1'b1;
                    prev_cr_next  = (data_byte == CH_CR);
                    if (is_space)
                    begin
                        in_tok_next = 1'b0;
                        rkind_next  = KIND_DELIM;
                    end
                    else
                    begin
                        in_tok_next  = 1'b1;
                        tok_cnt_next = tok_cnt_eff;
                        acc_next     = scan_acc;
                        flags_next   = scan_flags;
                        if (tok_cnt_eff == 3'd1)
                        begin
                            if (cmd_reg < CMD_FULL && data_byte == cmd_char)
                                cmd_next = cmd_reg + 3'd1;
                            else
                                cmd_next = CMD_MISMATCH;
                        end
                        rkind_next = KIND_TOKEN;
                        rtok_next  = (tok_cnt_eff > TOKEN_MAX_TAG + 3'd1) ? TOKEN_MAX_TAG
                                                                         : tok_cnt_eff - 3'd1;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                rkind_next = KIND_PAYLOAD;
                left_next  = left_reg - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                if (left_reg == {{(LENGTH_BITS-1){1'b0}}, 1'b1})
                    phase_next = PH_AWAIT_CR;
            end
            PH_AWAIT_CR:
            begin
                if (data_byte == CH_CR)
                begin
                    rkind_next = KIND_DELIM;
                    phase_next = PH_AWAIT_LF;
                end
                else
                begin
                    rkind_next = KIND_ERROR;
                    rerr_next  = ERR_NO_CR;
                    phase_next = PH_HEADER;
                end
            end
            PH_AWAIT_LF:
            begin
                if (data_byte == CH_LF)
                begin
                    rkind_next  = KIND_FRAME_OK;
                    rreply_next = held_reply_reg;
                    rlen_next   = held_len_reg;
                end
                else
                begin
                    rkind_next = KIND_ERROR;
                    rerr_next  = ERR_NO_LF;
                end
                phase_next = PH_HEADER;
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase
    end

    // Advance state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            prev_cr_reg    <= 1'b0;
            nonempty_reg   <= 1'b0;
            in_tok_reg     <= 1'b0;
            tok_cnt_reg    <= '0;
            cmd_reg        <= '0;
            acc_reg        <= '0;
            flags_reg      <= '0;
            left_reg       <= '0;
            held_len_reg   <= '0;
            held_reply_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg      <= phase_next;
            prev_cr_reg    <= prev_cr_next;
            nonempty_reg   <= nonempty_next;
            in_tok_reg     <= in_tok_next;
            tok_cnt_reg    <= tok_cnt_next;
            cmd_reg        <= cmd_next;
            acc_reg        <= acc_next;
            flags_reg      <= flags_next;
            left_reg       <= left_next;
            held_len_reg   <= held_len_next;
            held_reply_reg <= held_reply_next;
        end
    end

    // Limit register, written through the config channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= MAX_PAYLOAD_RESET;
        else if (cfg_valid && cfg_ready)
            limit_reg <= max_payload_bytes;
    end

    // Result register: load on accept, hold while stalled, clear valid when drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rvalid_reg <= 1'b0;
        else if (take)
            rvalid_reg <= 1'b1;
        else if (result_ready)
            rvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rbyte_reg  <= data_byte;
            rkind_reg  <= rkind_next;
            rtok_reg   <= rtok_next;
            rreply_reg <= rreply_next;
            rlen_reg   <= rlen_next;
            rerr_reg   <= rerr_next;
        end
    end

`ifndef SYNTH
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> left_reg != '0)
        else $error("payload phase with nothing left to count");

    a_error_coded: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg && rkind_reg == KIND_ERROR |-> rerr_reg != ERR_NONE)
        else $error("error result without a code");

    a_ok_uncoded: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg && rkind_reg != KIND_ERROR |-> rerr_reg == ERR_NONE)
        else $error("error code on a non-error result");

    a_tok_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        tok_cnt_reg <= TOKEN_CAP)
        else $error("token count past its cap");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> rvalid_reg)
        else $error("accepted beat left no result");
`endif

endmodule
